### hw/rtl/gmps_pkg.sv
// ----------------------------------------------------------------------------
// gmps_pkg: shared types and constants for the grid minimax path search
// Field widths, command and register codes, and the sequencer state type.
// ----------------------------------------------------------------------------
`default_nettype none

package gmps_pkg;

    localparam int CFG_W    = 6;
    localparam int COORD_W  = 5;
    localparam int HEIGHT_W = 16;
    localparam int INDEX_W  = 1;

    localparam logic [CFG_W-1:0] ROWS_RESET = 6'd32;
    localparam logic [CFG_W-1:0] COLS_RESET = 6'd32;

    localparam logic [INDEX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [INDEX_W-1:0] REG_COLS = 1'b1;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_CLEAR    = 16'h0002,
        ST_PUSH_ST  = 16'h0004,
        ST_PUSH_RD  = 16'h0008,
        ST_PUSH_CMP = 16'h0010,
        ST_NB_NEXT  = 16'h0020,
        ST_LOOP     = 16'h0040,
        ST_POP_RD0  = 16'h0080,
        ST_POP_LD   = 16'h0100,
        ST_POP_RD   = 16'h0200,
        ST_POP_CMP  = 16'h0400,
        ST_VIS_RD   = 16'h0800,
        ST_VIS_CHK  = 16'h1000,
        ST_NB_SEL   = 16'h2000,
        ST_NB_CHK   = 16'h4000,
        ST_DONE     = 16'h8000
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/gmps_if.sv
// ----------------------------------------------------------------------------
// gmps_if: request and response channels
// Valid/ready channels carrying one request word or one response word.
// ----------------------------------------------------------------------------
`default_nettype none

interface gmps_req_if;
    logic                            valid;
    logic                            ready;
    logic                            cmd;
    logic [gmps_pkg::COORD_W-1:0]    cell_row;
    logic [gmps_pkg::COORD_W-1:0]    cell_col;
    logic [gmps_pkg::HEIGHT_W-1:0]   height;
    logic [gmps_pkg::COORD_W-1:0]    dest_row;
    logic [gmps_pkg::COORD_W-1:0]    dest_col;

    modport source (output valid, cmd, cell_row, cell_col, height, dest_row, dest_col,
                    input ready);
    modport sink (input valid, cmd, cell_row, cell_col, height, dest_row, dest_col,
                  output ready);
endinterface

interface gmps_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [gmps_pkg::HEIGHT_W-1:0]   ladder_height;
    logic                            bad_request;

    modport source (output valid, ladder_height, bad_request, input ready);
    modport sink (input valid, ladder_height, bad_request, output ready);
endinterface

`default_nettype wire

### hw/rtl/grid_minimax_path_search_core.sv
// ----------------------------------------------------------------------------
// grid_minimax_path_search_core: minimax ladder search over a height grid
// Sequencer driving a height RAM, a visited RAM and a binary-heap frontier RAM.
// ----------------------------------------------------------------------------
// A load word writes one cell height and leaves the block idle and ready for
// the next word. A query word runs a Prim-style search and returns one
// response word; a query naming a cell outside the configured grid goes
// straight to the done state and answers with bad_request set. A valid query
// first sweeps the whole visited RAM, then for each popped cell reads the heap
// root and last entry, sifts down one heap level per read and compare step,
// checks the visited bit and tests each neighbor; a push sifts up one level per
// read and compare step. The done state loads the response register, waiting
// while an unread word is held. There is a single heap RAM (one write, two read
// ports) and one sequencer; the block accepts no word while a query runs. No clearing pass follows reset.
`default_nettype none

module grid_minimax_path_search_core #(
    parameter int MAX_ROWS       = 32,
    parameter int MAX_COLS       = 32,
    parameter int HEIGHT_BITS    = 16,
    parameter int FRONTIER_DEPTH = 4096
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    gmps_req_if.sink                            req,
    gmps_rsp_if.source                          rsp,
    input  wire logic                           wr_en,
    input  wire logic [gmps_pkg::INDEX_W-1:0]   wr_index,
    input  wire logic [gmps_pkg::CFG_W-1:0]     wr_data
);

    localparam int CELLS = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_ROWS);
    localparam int CW    = $clog2(MAX_COLS);
    localparam int NRW   = $clog2(MAX_ROWS + 1);
    localparam int NCW   = $clog2(MAX_COLS + 1);
    localparam int KW    = HEIGHT_BITS + RW + CW;
    localparam int HAW   = $clog2(FRONTIER_DEPTH);
    localparam int CNTW  = $clog2(FRONTIER_DEPTH + 1);
    localparam int CHW   = HAW + 1;

    gmps_pkg::state_t state_reg, state_next;

    logic [gmps_pkg::CFG_W-1:0] rows_reg, cols_reg;
    logic [NRW-1:0]         nr_reg, nr_next;
    logic [NCW-1:0]         nc_reg, nc_next;
    logic [RW-1:0]          dst_r_reg, dst_r_next;
    logic [CW-1:0]          dst_c_reg, dst_c_next;
    logic                   dst_vis_reg, dst_vis_next;
    logic [CNTW-1:0]        count_reg, count_next;
    logic [HAW-1:0]         idx_reg, idx_next;
    logic [KW-1:0]          key_reg, key_next;
    logic [KW-1:0]          top_reg, top_next;
    logic [KW-1:0]          last_reg, last_next;
    logic [HEIGHT_BITS-1:0] worst_reg, worst_next;
    logic [HEIGHT_BITS-1:0] hcur_reg, hcur_next;
    logic [1:0]             dir_reg, dir_next;
    logic [RW-1:0]          nb_r_reg, nb_r_next;
    logic [CW-1:0]          nb_c_reg, nb_c_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   res_bad_reg, res_bad_next;
    logic                   out_valid_reg, out_valid_next;
    logic [gmps_pkg::HEIGHT_W-1:0] out_h_reg, out_h_next;
    logic                   out_bad_reg, out_bad_next;

    // height RAM
    logic                   ht_we;
    logic [AW-1:0]          ht_waddr, ht_raddr;
    logic [HEIGHT_BITS-1:0] ht_wdata, ht_rdata;
    // visited RAM
    logic                   vs_we;
    logic [AW-1:0]          vs_waddr, vs_raddr;
    logic                   vs_wdata, vs_rdata;
    // heap RAM
    logic                   hp_we;
    logic [HAW-1:0]         hp_waddr, hp_ra, hp_rb;
    logic [KW-1:0]          hp_wdata, hp_da, hp_db;

    function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                                input logic [CW-1:0] c);
        cell_addr = AW'(32'(r) * MAX_COLS + 32'(c));
    endfunction

    gmps_ram #(.WIDTH(HEIGHT_BITS), .DEPTH(CELLS)) u_height_ram (
        .clk(clk), .we(ht_we), .wr_addr(ht_waddr), .wr_data(ht_wdata),
        .rd_addr_a(ht_raddr), .rd_data_a(ht_rdata),
        .rd_addr_b(ht_raddr), .rd_data_b()
    );

    gmps_ram #(.WIDTH(1), .DEPTH(CELLS)) u_visited_ram (
        .clk(clk), .we(vs_we), .wr_addr(vs_waddr), .wr_data(vs_wdata),
        .rd_addr_a(vs_raddr), .rd_data_a(vs_rdata),
        .rd_addr_b(vs_raddr), .rd_data_b()
    );

    gmps_ram #(.WIDTH(KW), .DEPTH(FRONTIER_DEPTH)) u_heap_ram (
        .clk(clk), .we(hp_we), .wr_addr(hp_waddr), .wr_data(hp_wdata),
        .rd_addr_a(hp_ra), .rd_data_a(hp_da),
        .rd_addr_b(hp_rb), .rd_data_b(hp_db)
    );

    // fields of the popped key
    logic [HEIGHT_BITS-1:0] top_step;
    logic [RW-1:0]          top_r;
    logic [CW-1:0]          top_c;
    assign top_step = top_reg[KW-1 -: HEIGHT_BITS];
    assign top_r    = top_reg[CW +: RW];
    assign top_c    = top_reg[CW-1:0];

    logic [CHW-1:0] child;
    logic [HAW-1:0] parent;
    assign child  = {idx_reg, 1'b1};
    assign parent = HAW'((idx_reg - HAW'(1)) >> 1);

    logic [31:0] nr_sat, nc_sat;
    assign nr_sat = (32'(rows_reg) > MAX_ROWS) ? MAX_ROWS : 32'(rows_reg);
    assign nc_sat = (32'(cols_reg) > MAX_COLS) ? MAX_COLS : 32'(cols_reg);

    assign req.ready = (state_reg == gmps_pkg::ST_IDLE);
    assign rsp.valid = out_valid_reg;
    assign rsp.ladder_height = out_h_reg;
    assign rsp.bad_request = out_bad_reg;

    logic                   nb_ok;
    logic [RW-1:0]          nb_r;
    logic [CW-1:0]          nb_c;
    logic [HEIGHT_BITS-1:0] diff;
    logic                   pick_b;
    logic [KW-1:0]          chosen;
    logic                   bad;

    always_comb
    begin
        nb_ok = 1'b0;
        nb_r  = top_r;
        nb_c  = top_c;
        unique case (dir_reg)
            2'd0:
            begin
                nb_ok = (top_r != '0);
                nb_r  = top_r - RW'(1);
            end
            2'd1:
            begin
                nb_ok = (32'(top_r) + 32'd1 < 32'(nr_reg));
                nb_r  = top_r + RW'(1);
            end
            2'd2:
            begin
                nb_ok = (top_c != '0);
                nb_c  = top_c - CW'(1);
            end
            default:
            begin
                nb_ok = (32'(top_c) + 32'd1 < 32'(nc_reg));
                nb_c  = top_c + CW'(1);
            end
        endcase
    end

    assign diff   = (hcur_reg > ht_rdata) ? hcur_reg - ht_rdata : ht_rdata - hcur_reg;
    assign pick_b = (32'(child) + 32'd1 < 32'(count_reg)) && (hp_db < hp_da);
    assign chosen = pick_b ? hp_db : hp_da;
    assign bad    = (32'(req.cell_row) >= nr_sat) || (32'(req.cell_col) >= nc_sat) ||
                    (32'(req.dest_row) >= nr_sat) || (32'(req.dest_col) >= nc_sat);

    always_comb
    begin
        state_next   = state_reg;
        nr_next      = nr_reg;
        nc_next      = nc_reg;
        dst_r_next   = dst_r_reg;
        dst_c_next   = dst_c_reg;
        dst_vis_next = dst_vis_reg;
        count_next   = count_reg;
        idx_next     = idx_reg;
        key_next     = key_reg;
        top_next     = top_reg;
        last_next    = last_reg;
        worst_next   = worst_reg;
        hcur_next    = hcur_reg;
        dir_next     = dir_reg;
        nb_r_next    = nb_r_reg;
        nb_c_next    = nb_c_reg;
        clr_next     = clr_reg;
        res_bad_next = res_bad_reg;
        out_h_next   = out_h_reg;
        out_bad_next = out_bad_reg;
        out_valid_next = out_valid_reg && !rsp.ready;

        ht_we    = 1'b0;
        ht_waddr = cell_addr(RW'(req.cell_row), CW'(req.cell_col));
        ht_wdata = HEIGHT_BITS'(req.height);
        ht_raddr = cell_addr(top_r, top_c);
        vs_we    = 1'b0;
        vs_waddr = clr_reg;
        vs_wdata = 1'b0;
        vs_raddr = cell_addr(top_r, top_c);
        hp_we    = 1'b0;
        hp_waddr = idx_reg;
        hp_wdata = key_reg;
        hp_ra    = parent;
        hp_rb    = HAW'(child + CHW'(1));

        unique case (state_reg)
            gmps_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    if (req.cmd == gmps_pkg::CMD_LOAD)
                    begin
                        ht_we = (32'(req.cell_row) < MAX_ROWS) &&
                                (32'(req.cell_col) < MAX_COLS);
                    end
                    else if (bad)
                    begin
                        // response register may still hold an unread word
                        res_bad_next = 1'b1;
                        state_next   = gmps_pkg::ST_DONE;
                    end
                    else
                    begin
                        nr_next    = NRW'(nr_sat);
                        nc_next    = NCW'(nc_sat);
                        dst_r_next = RW'(req.dest_row);
                        dst_c_next = CW'(req.dest_col);
                        key_next   = {{HEIGHT_BITS{1'b0}}, RW'(req.cell_row),
                                      CW'(req.cell_col)};
                        clr_next   = '0;
                        state_next = gmps_pkg::ST_CLEAR;
                    end
                end
            end
            gmps_pkg::ST_CLEAR:
            begin
                vs_we    = 1'b1;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(CELLS - 1))
                begin
                    count_next   = '0;
                    worst_next   = '0;
                    dst_vis_next = 1'b0;
                    dir_next     = 2'd3;   // source push returns straight to the loop
                    state_next   = gmps_pkg::ST_PUSH_ST;
                end
            end
            gmps_pkg::ST_PUSH_ST:
            begin
                if (32'(count_reg) >= FRONTIER_DEPTH)
                begin
                    state_next = gmps_pkg::ST_NB_NEXT;
                end
                else
                begin
                    idx_next   = HAW'(count_reg);
                    count_next = count_reg + CNTW'(1);
                    state_next = gmps_pkg::ST_PUSH_RD;
                end
            end
            gmps_pkg::ST_PUSH_RD:
            begin
                if (idx_reg == '0)
                begin
                    hp_we      = 1'b1;
                    state_next = gmps_pkg::ST_NB_NEXT;
                end
                else
                begin
                    state_next = gmps_pkg::ST_PUSH_CMP;
                end
            end
            gmps_pkg::ST_PUSH_CMP:
            begin
                hp_we = 1'b1;
                if (hp_da <= key_reg)
                begin
                    state_next = gmps_pkg::ST_NB_NEXT;
                end
                else
                begin
                    hp_wdata   = hp_da;
                    idx_next   = parent;
                    state_next = gmps_pkg::ST_PUSH_RD;
                end
            end
            gmps_pkg::ST_NB_NEXT:
            begin
                if (dir_reg == 2'd3)
                begin
                    state_next = gmps_pkg::ST_LOOP;
                end
                else
                begin
                    dir_next   = dir_reg + 2'd1;
                    state_next = gmps_pkg::ST_NB_SEL;
                end
            end
            gmps_pkg::ST_LOOP:
            begin
                if (dst_vis_reg || count_reg == '0)
                begin
                    res_bad_next = 1'b0;
                    state_next   = gmps_pkg::ST_DONE;
                end
                else
                begin
                    state_next = gmps_pkg::ST_POP_RD0;
                end
            end
            gmps_pkg::ST_POP_RD0:
            begin
                hp_ra      = '0;
                hp_rb      = HAW'(count_reg - CNTW'(1));
                state_next = gmps_pkg::ST_POP_LD;
            end
            gmps_pkg::ST_POP_LD:
            begin
                top_next   = hp_da;
                last_next  = hp_db;
                count_next = count_reg - CNTW'(1);
                idx_next   = '0;
                state_next = gmps_pkg::ST_POP_RD;
            end
            gmps_pkg::ST_POP_RD:
            begin
                hp_ra = HAW'(child);
                if (32'(child) >= 32'(count_reg))
                begin
                    hp_we      = (count_reg != '0);
                    hp_wdata   = last_reg;
                    state_next = gmps_pkg::ST_VIS_RD;
                end
                else
                begin
                    state_next = gmps_pkg::ST_POP_CMP;
                end
            end
            gmps_pkg::ST_POP_CMP:
            begin
                hp_we = 1'b1;
                if (chosen >= last_reg)
                begin
                    hp_wdata   = last_reg;
                    state_next = gmps_pkg::ST_VIS_RD;
                end
                else
                begin
                    hp_wdata   = chosen;
                    idx_next   = pick_b ? HAW'(child + CHW'(1)) : HAW'(child);
                    state_next = gmps_pkg::ST_POP_RD;
                end
            end
            gmps_pkg::ST_VIS_RD:
            begin
                state_next = gmps_pkg::ST_VIS_CHK;
            end
            gmps_pkg::ST_VIS_CHK:
            begin
                if (vs_rdata)
                begin
                    state_next = gmps_pkg::ST_LOOP;
                end
                else
                begin
                    if (top_step > worst_reg)
                    begin
                        worst_next = top_step;
                    end
                    vs_we    = 1'b1;
                    vs_waddr = cell_addr(top_r, top_c);
                    vs_wdata = 1'b1;
                    if (top_r == dst_r_reg && top_c == dst_c_reg)
                    begin
                        dst_vis_next = 1'b1;
                    end
                    hcur_next  = ht_rdata;
                    dir_next   = 2'd0;
                    state_next = gmps_pkg::ST_NB_SEL;
                end
            end
            gmps_pkg::ST_NB_SEL:
            begin
                ht_raddr  = cell_addr(nb_r, nb_c);
                vs_raddr  = cell_addr(nb_r, nb_c);
                nb_r_next = nb_r;
                nb_c_next = nb_c;
                state_next = nb_ok ? gmps_pkg::ST_NB_CHK : gmps_pkg::ST_NB_NEXT;
            end
            gmps_pkg::ST_NB_CHK:
            begin
                if (!vs_rdata)
                begin
                    key_next   = {diff, nb_r_reg, nb_c_reg};
                    state_next = gmps_pkg::ST_PUSH_ST;
                end
                else
                begin
                    state_next = gmps_pkg::ST_NB_NEXT;
                end
            end
            gmps_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_h_next     = res_bad_reg ? '0 :
                                     ((32'(worst_reg) > 32'd65535) ? 16'hFFFF :
                                                                     16'(worst_reg));
                    out_bad_next   = res_bad_reg;
                    out_valid_next = 1'b1;
                    state_next     = gmps_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gmps_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= gmps_pkg::ST_IDLE;
            rows_reg      <= gmps_pkg::ROWS_RESET;
            cols_reg      <= gmps_pkg::COLS_RESET;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            worst_reg     <= '0;
            dst_vis_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            count_reg     <= count_next;
            worst_reg     <= worst_next;
            dst_vis_reg   <= dst_vis_next;
            if (wr_en && wr_index == gmps_pkg::REG_ROWS)
            begin
                rows_reg <= wr_data;
            end
            if (wr_en && wr_index == gmps_pkg::REG_COLS)
            begin
                cols_reg <= wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        nr_reg    <= nr_next;
        nc_reg    <= nc_next;
        dst_r_reg <= dst_r_next;
        dst_c_reg <= dst_c_next;
        idx_reg   <= idx_next;
        key_reg   <= key_next;
        top_reg   <= top_next;
        last_reg  <= last_next;
        hcur_reg  <= hcur_next;
        dir_reg   <= dir_next;
        nb_r_reg  <= nb_r_next;
        nb_c_reg  <= nb_c_next;
        clr_reg   <= clr_next;
        res_bad_reg <= res_bad_next;
        out_h_reg <= out_h_next;
        out_bad_reg <= out_bad_next;
    end

endmodule

`default_nettype wire

### hw/rtl/gmps_ram.sv
// ----------------------------------------------------------------------------
// gmps_ram: generic RAM
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module gmps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output      logic [WIDTH-1:0]         rd_data_a,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output      logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

### verif/grid_minimax_path_search_core_tb.sv
// ----------------------------------------------------------------------------
// grid_minimax_path_search_core_tb: self-checking bench for the ladder search
// Loads height grids, runs path queries under random idling on both channels
// and compares each response word with a minimax path predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class ladder_scoreboard;
    logic [16:0] pending[$];
    int          errors;

    function new();
        errors = 0;
    endfunction

    task report(string msg);
        $display("ERROR: %s", msg);
        errors++;
    endtask

    function void note(logic [15:0] ladder, logic bad);
        pending.push_back({bad, ladder});
    endfunction

    task check(logic [15:0] ladder, logic bad);
        logic [16:0] want;
        if (pending.size() == 0)
        begin
            report($sformatf("unexpected response word ladder=%0d bad=%0b", ladder, bad));
            return;
        end
        want = pending.pop_front();
        if (bad !== want[16] || ladder !== want[15:0])
        begin
            report($sformatf("got ladder=%0d bad=%0b want ladder=%0d bad=%0b",
                             ladder, bad, want[15:0], want[16]));
        end
    endtask
endclass

module grid_minimax_path_search_core_tb;

    localparam int NROWS = 32;
    localparam int NCOLS = 32;
    localparam int CYCLE_LIMIT = 3000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                          wr_en = 1'b0;
    logic [gmps_pkg::INDEX_W-1:0]  wr_index = gmps_pkg::REG_ROWS;
    logic [gmps_pkg::CFG_W-1:0]    wr_data = '0;

    gmps_req_if req ();
    gmps_rsp_if rsp ();

    grid_minimax_path_search_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (req.sink),
        .rsp      (rsp.source),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    always #1 clk = ~clk;

    ladder_scoreboard board = new();

    // predictor copy of the grid and registers
    logic [15:0] grid_h[NROWS*NCOLS];
    int          rows_cfg;
    int          cols_cfg;
    bit          calm;
    int          cycles = 0;

    // Minimax step via repeated relaxation; answer is tie-order independent.
    function automatic logic [15:0] minimax_step(int src, int dst, int nr, int nc);
        int best[NROWS*NCOLS];
        bit changed;
        int r, c, i, nb, d, v, k;
        for (i = 0; i < NROWS*NCOLS; i++)
            best[i] = 32'h7fffffff;
        best[src] = 0;
        changed = 1;
        while (changed)
        begin
            changed = 0;
            for (r = 0; r < nr; r++)
                for (c = 0; c < nc; c++)
                begin
                    i = r*NCOLS + c;
                    if (best[i] == 32'h7fffffff)
                        continue;
                    for (k = 0; k < 4; k++)
                    begin
                        if (k == 0 && r == 0) continue;
                        if (k == 1 && r+1 >= nr) continue;
                        if (k == 2 && c == 0) continue;
                        if (k == 3 && c+1 >= nc) continue;
                        nb = (k == 0) ? i-NCOLS : (k == 1) ? i+NCOLS : (k == 2) ? i-1 : i+1;
                        d = (grid_h[i] > grid_h[nb]) ? grid_h[i]-grid_h[nb]
                                                     : grid_h[nb]-grid_h[i];
                        v = (d > best[i]) ? d : best[i];
                        if (v < best[nb])
                        begin
                            best[nb] = v;
                            changed = 1;
                        end
                    end
                end
        end
        return best[dst][15:0];
    endfunction

    // valid stays up between words unless a gap is taken
    task automatic idle_gap();
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    endtask

    task automatic send_word(logic cmd, logic [4:0] r1, logic [4:0] c1, logic [15:0] h,
                             logic [4:0] r2, logic [4:0] c2);
        int nr, nc;
        idle_gap();
        req.valid    <= 1'b1;
        req.cmd      <= cmd;
        req.cell_row <= r1;
        req.cell_col <= c1;
        req.height   <= h;
        req.dest_row <= r2;
        req.dest_col <= c2;
        do @(posedge clk); while (!req.ready);
        if (cmd == gmps_pkg::CMD_LOAD)
        begin
            grid_h[r1*NCOLS + c1] = h;
        end
        else
        begin
            nr = (rows_cfg > NROWS) ? NROWS : rows_cfg;
            nc = (cols_cfg > NCOLS) ? NCOLS : cols_cfg;
            if (r1 >= nr || c1 >= nc || r2 >= nr || c2 >= nc)
                board.note(16'd0, 1'b1);
            else
                board.note(minimax_step(r1*NCOLS + c1, r2*NCOLS + c2, nr, nc), 1'b0);
        end
    endtask

    task automatic drain();
        req.valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(logic [gmps_pkg::INDEX_W-1:0] idx, int val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val[gmps_pkg::CFG_W-1:0];
        @(posedge clk);
        wr_en <= 1'b0;
        @(posedge clk);
        if (idx == gmps_pkg::REG_ROWS)
            rows_cfg = val & 63;
        else
            cols_cfg = val & 63;
    endtask

    // load every cell of the active window with random heights
    task automatic load_window(int nr, int nc, int span);
        for (int r = 0; r < nr; r++)
            for (int c = 0; c < nc; c++)
                send_word(gmps_pkg::CMD_LOAD, r[4:0], c[4:0], 16'($urandom_range(0, span)),
                          5'($urandom), 5'($urandom));
    endtask

    // query inside the window, occasionally outside
    task automatic random_query(int nr, int nc);
        if ($urandom_range(0, 5) == 0)
            send_word(gmps_pkg::CMD_QUERY, 5'($urandom), 5'($urandom), 16'($urandom),
                      5'($urandom), 5'($urandom));
        else
            send_word(gmps_pkg::CMD_QUERY, 5'($urandom_range(0, nr-1)),
                      5'($urandom_range(0, nc-1)), 16'($urandom),
                      5'($urandom_range(0, nr-1)), 5'($urandom_range(0, nc-1)));
    endtask

    // response side with random backpressure
    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            board.check(rsp.ladder_height, rsp.bad_request);
        if (!rst_n || calm)
            rsp.ready <= 1'b1;
        else if ($urandom_range(0, 3) == 0)
            rsp.ready <= 1'b0;
        else
            rsp.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin
        int nr, nc;
        calm = 0;
        rows_cfg = 32;
        cols_cfg = 32;
        req.valid = 1'b0;
        req.cmd = gmps_pkg::CMD_LOAD;
        req.cell_row = '0;
        req.cell_col = '0;
        req.height = '0;
        req.dest_row = '0;
        req.dest_col = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: 2x2 window with height extremes
        write_reg(gmps_pkg::REG_ROWS, 2);
        write_reg(gmps_pkg::REG_COLS, 2);
        send_word(gmps_pkg::CMD_LOAD, 5'd0, 5'd0, 16'h0000, 5'd31, 5'd31);
        send_word(gmps_pkg::CMD_LOAD, 5'd0, 5'd1, 16'hffff, 5'd0, 5'd0);
        send_word(gmps_pkg::CMD_LOAD, 5'd1, 5'd0, 16'h8000, 5'd0, 5'd0);
        send_word(gmps_pkg::CMD_LOAD, 5'd1, 5'd1, 16'h5555, 5'd0, 5'd0);
        send_word(gmps_pkg::CMD_LOAD, 5'd31, 5'd31, 16'haaaa, 5'd0, 5'd0);
        send_word(gmps_pkg::CMD_QUERY, 5'd0, 5'd0, 16'hffff, 5'd1, 5'd1);
        send_word(gmps_pkg::CMD_QUERY, 5'd1, 5'd1, 16'h0000, 5'd1, 5'd1);  // same cell
        send_word(gmps_pkg::CMD_QUERY, 5'd0, 5'd1, 16'h0000, 5'd1, 5'd0);
        send_word(gmps_pkg::CMD_QUERY, 5'd2, 5'd0, 16'h0000, 5'd0, 5'd0);  // outside grid
        send_word(gmps_pkg::CMD_QUERY, 5'd0, 5'd0, 16'h0000, 5'd0, 5'd31);
        send_word(gmps_pkg::CMD_QUERY, 5'd31, 5'd31, 16'h0000, 5'd0, 5'd0);
        drain();
        // empty grid: every query is bad
        write_reg(gmps_pkg::REG_ROWS, 0);
        send_word(gmps_pkg::CMD_QUERY, 5'd0, 5'd0, 16'h0000, 5'd0, 5'd0);
        drain();
        // above range saturates
        write_reg(gmps_pkg::REG_ROWS, 63);
        write_reg(gmps_pkg::REG_COLS, 1);
        load_window(32, 1, 65535);
        send_word(gmps_pkg::CMD_QUERY, 5'd0, 5'd0, 16'h0000, 5'd31, 5'd0);
        send_word(gmps_pkg::CMD_QUERY, 5'd31, 5'd0, 16'h0000, 5'd0, 5'd0);
        drain();
        // long path: one query down the single column, drained before the next phase
        send_word(gmps_pkg::CMD_QUERY, 5'd5, 5'd0, 16'h0000, 5'd20, 5'd0);
        drain();

        // random phases over several window shapes
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin nr = 4; nc = 4; end
                1: begin nr = 1; nc = 12; end
                2: begin nr = 3; nc = 3; end
                3: begin nr = 5; nc = 2; end
                4: begin nr = 2; nc = 8; end
                default: begin nr = 3; nc = 4; end
            endcase
            write_reg(gmps_pkg::REG_ROWS, nr);
            write_reg(gmps_pkg::REG_COLS, nc);
            if (ph == 5)
                calm = 1;
            load_window(nr, nc, ($urandom_range(0, 1) != 0) ? 65535 : 15);
            for (int q = 0; q < 4; q++)
                random_query(nr, nc);
            drain();
        end

        drain();
        if (board.errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
